// ===== rtl/core/tdgc_pkg.sv =====
// tdgc_pkg: types and constants shared by the drive and gimbal command unit
// holds the controller state type, the command and status structs, register indexes
// no dependencies
package tdgc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic mul3;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic signed [17:0] pos;
        logic [10:0]        rate;
        logic               hit;
        logic               fault;
    } t_axis_res;

    // configuration register indexes
    localparam logic [2:0] CFG_SPIN_THRESHOLD    = 3'd0;
    localparam logic [2:0] CFG_DUTY_FULL_SCALE   = 3'd1;
    localparam logic [2:0] CFG_PAN_POS_LIMIT     = 3'd2;
    localparam logic [2:0] CFG_PAN_NEG_LIMIT     = 3'd3;
    localparam logic [2:0] CFG_TILT_TOP_LIMIT    = 3'd4;
    localparam logic [2:0] CFG_TILT_BOTTOM_LIMIT = 3'd5;
    localparam logic [2:0] CFG_PAN_MAX_RATE      = 3'd6;
    localparam logic [2:0] CFG_TILT_MAX_RATE     = 3'd7;

    // reset values
    localparam logic [6:0]  RST_SPIN_THRESHOLD    = 7'd80;
    localparam logic [19:0] RST_DUTY_FULL_SCALE   = 20'd500000;
    localparam logic [15:0] RST_PAN_POS_LIMIT     = 16'd28000;
    localparam logic [15:0] RST_PAN_NEG_LIMIT     = 16'd28000;
    localparam logic [15:0] RST_TILT_TOP_LIMIT    = 16'd18000;
    localparam logic [15:0] RST_TILT_BOTTOM_LIMIT = 16'd18000;
    localparam logic [15:0] RST_PAN_MAX_RATE      = 16'd50000;
    localparam logic [15:0] RST_TILT_MAX_RATE     = 16'd5000;

    localparam logic [7:0]  SPIN_SPEED = 8'd90;
    localparam logic [27:0] DUTY_MAX   = 28'hFFFFFFF;

    // ceil(2^34/127): exact floor division by 127 for 27-bit values
    localparam logic [27:0] RECIP_127_L = 28'd135274561;
    localparam int          RECIP_L_SH  = 34;
    // ceil(2^22/127): exact floor division by 127 for 15-bit values
    localparam logic [15:0] RECIP_127_S = 16'd33027;
    localparam int          RECIP_S_SH  = 22;

    localparam logic signed [18:0] POS_MAX = 19'sd131071;
    localparam logic signed [18:0] POS_MIN = -19'sd131072;

endpackage

// ===== rtl/core/tdgc_ctrl.sv =====
// tdgc_ctrl: sequencer for the drive and gimbal command unit
// steps the datapath through its multiply stages; depends on tdgc_pkg
module tdgc_ctrl
    import tdgc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL1;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_MUL3;
            end
            ST_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = ST_FIN;
            end
            ST_FIN: begin
                // hold until the result register can take the new request
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/tdgc_dp.sv =====
// tdgc_dp: datapath of the drive and gimbal command unit
// config registers, track duty multiply chain, gimbal soft limits, result register
// depends on tdgc_pkg
module tdgc_dp
    import tdgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [39:0] i_in_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    output logic [87:0] o_out_data,
    output logic        o_out_valid,
    input  logic        i_out_ready
);

    // configuration
    logic [6:0]  r_spin_thr;
    logic [19:0] r_full_scale;
    logic [15:0] r_pan_pos_lim;
    logic [15:0] r_pan_neg_lim;
    logic [15:0] r_tilt_top_lim;
    logic [15:0] r_tilt_bot_lim;
    logic [15:0] r_pan_max_rate;
    logic [15:0] r_tilt_max_rate;

    // latched request
    logic signed [7:0] r_turn;
    logic signed [7:0] r_throttle;
    logic signed [7:0] r_pan_in;
    logic signed [7:0] r_tilt_in;
    logic [8:0]        r_mult;

    // gimbal state and staged results
    logic signed [17:0] r_pan_pos;
    logic signed [17:0] r_tilt_pos;
    t_axis_res          r_pan_res;
    t_axis_res          r_tilt_res;

    // duty chain
    logic [26:0] r_y;
    logic [20:0] r_q;
    logic [29:0] r_p;
    logic [14:0] r_v;

    logic        r_out_valid;
    logic [87:0] r_out_data;

    logic              w_spin_r;
    logic              w_spin_l;
    logic signed [7:0] w_neg_thr;
    logic              w_right_fwd;
    logic              w_left_fwd;
    logic [7:0]        w_mag;
    logic [27:0]       w_y;
    logic [54:0]       w_qprod;
    logic [27:0]       w_q127;
    logic [26:0]       w_rem;
    logic [29:0]       w_p;
    logic [15:0]       w_v;
    logic [30:0]       w_tprod;
    logic [29:0]       w_sum;
    logic [27:0]       w_duty;
    t_axis_res         w_pan_res;
    t_axis_res         w_tilt_res;

    function automatic t_axis_res f_axis(
        input logic signed [7:0]  g_in,
        input logic signed [17:0] pos,
        input logic [15:0]        lim_p,
        input logic [15:0]        lim_n,
        input logic [15:0]        max_rate
    );
        logic signed [10:0] cmd;
        logic signed [17:0] lim_hi;
        logic signed [17:0] lim_lo;
        logic signed [18:0] sum;
        logic [10:0]        mag;
        t_axis_res          res;
        cmd       = {g_in, 3'b000};
        lim_hi    = $signed({2'b00, lim_p});
        lim_lo    = $signed(18'd0 - {2'b00, lim_n});
        res.hit   = 1'b0;
        res.fault = 1'b0;
        if ((pos > lim_hi) && (cmd > 11'sd0)) begin
            cmd     = 11'sd0;
            res.hit = 1'b1;
        end else if ((pos < lim_lo) && (cmd < 11'sd0)) begin
            cmd     = 11'sd0;
            res.hit = 1'b1;
        end
        sum = pos + cmd;
        if (sum > POS_MAX) begin
            res.pos = POS_MAX[17:0];
        end else if (sum < POS_MIN) begin
            res.pos = POS_MIN[17:0];
        end else begin
            res.pos = sum[17:0];
        end
        mag = cmd[10] ? 11'(-cmd) : 11'(cmd);
        if ({5'd0, mag} > max_rate) begin
            res.rate  = 11'd0;
            res.fault = 1'b1;
        end else begin
            res.rate = mag;
        end
        return res;
    endfunction

    // track speeds: both tracks always share one magnitude
    always_comb begin
        w_neg_thr = $signed(8'd0 - {1'b0, r_spin_thr});
        w_spin_r  = r_turn > $signed({1'b0, r_spin_thr});
        w_spin_l  = r_turn < w_neg_thr;
        if (w_spin_r) begin
            w_right_fwd = 1'b0;
            w_left_fwd  = 1'b1;
            w_mag       = SPIN_SPEED;
        end else if (w_spin_l) begin
            w_right_fwd = 1'b1;
            w_left_fwd  = 1'b0;
            w_mag       = SPIN_SPEED;
        end else begin
            w_right_fwd = ~r_throttle[7];
            w_left_fwd  = ~r_throttle[7];
            w_mag       = r_throttle[7] ? 8'(8'd0 - r_throttle) : r_throttle;
        end
    end

    assign w_pan_res  = f_axis(r_pan_in, r_pan_pos, r_pan_pos_lim, r_pan_neg_lim,
                               r_pan_max_rate);
    assign w_tilt_res = f_axis(r_tilt_in, r_tilt_pos, r_tilt_top_lim, r_tilt_bot_lim,
                               r_tilt_max_rate);

    // duty = mult * (y div 127) + (mult * (y mod 127)) div 127, y = full_scale * mag
    assign w_y     = {8'd0, r_full_scale} * {20'd0, w_mag};
    assign w_qprod = {28'd0, r_y} * {27'd0, RECIP_127_L};
    assign w_q127  = {r_q, 7'd0} - {7'd0, r_q};
    assign w_rem   = r_y - w_q127[26:0];
    assign w_p     = {9'd0, r_q} * {21'd0, r_mult};
    assign w_v     = {7'd0, r_mult} * {9'd0, w_rem[6:0]};
    assign w_tprod = {16'd0, r_v} * {15'd0, RECIP_127_S};
    assign w_sum   = r_p + {21'd0, w_tprod[RECIP_S_SH +: 9]};
    assign w_duty  = (w_sum > {2'b00, DUTY_MAX}) ? DUTY_MAX : w_sum[27:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spin_thr      <= RST_SPIN_THRESHOLD;
            r_full_scale    <= RST_DUTY_FULL_SCALE;
            r_pan_pos_lim   <= RST_PAN_POS_LIMIT;
            r_pan_neg_lim   <= RST_PAN_NEG_LIMIT;
            r_tilt_top_lim  <= RST_TILT_TOP_LIMIT;
            r_tilt_bot_lim  <= RST_TILT_BOTTOM_LIMIT;
            r_pan_max_rate  <= RST_PAN_MAX_RATE;
            r_tilt_max_rate <= RST_TILT_MAX_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPIN_THRESHOLD:    r_spin_thr      <= i_cfg_data[6:0];
                CFG_DUTY_FULL_SCALE:   r_full_scale    <= i_cfg_data;
                CFG_PAN_POS_LIMIT:     r_pan_pos_lim   <= i_cfg_data[15:0];
                CFG_PAN_NEG_LIMIT:     r_pan_neg_lim   <= i_cfg_data[15:0];
                CFG_TILT_TOP_LIMIT:    r_tilt_top_lim  <= i_cfg_data[15:0];
                CFG_TILT_BOTTOM_LIMIT: r_tilt_bot_lim  <= i_cfg_data[15:0];
                CFG_PAN_MAX_RATE:      r_pan_max_rate  <= i_cfg_data[15:0];
                CFG_TILT_MAX_RATE:     r_tilt_max_rate <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_pos  <= '0;
            r_tilt_pos <= '0;
        end else if (i_cmd.mul1) begin
            r_pan_pos  <= w_pan_res.pos;
            r_tilt_pos <= w_tilt_res.pos;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_turn     <= $signed(i_in_data[7:0]);
            r_throttle <= $signed(i_in_data[15:8]);
            r_pan_in   <= $signed(i_in_data[23:16]);
            r_tilt_in  <= $signed(i_in_data[31:24]);
            r_mult     <= {1'b0, i_in_data[39:32]} + 9'd1;
        end
        if (i_cmd.mul1) begin
            r_y        <= w_y[26:0];
            r_pan_res  <= w_pan_res;
            r_tilt_res <= w_tilt_res;
        end
        if (i_cmd.mul2) begin
            r_q <= w_qprod[RECIP_L_SH +: 21];
        end
        if (i_cmd.mul3) begin
            r_p <= w_p;
            r_v <= w_v[14:0];
        end
        if (i_cmd.fin) begin
            r_out_data <= {2'b00,
                           r_tilt_res.fault, r_pan_res.fault,
                           r_tilt_res.hit, r_pan_res.hit,
                           r_tilt_res.rate, r_pan_res.rate,
                           ~r_tilt_in[7], ~r_pan_in[7],
                           w_duty, w_duty,
                           w_left_fwd, w_right_fwd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

// ===== rtl/core/teleop_drive_and_gimbal_command_unit.sv =====
// teleop_drive_and_gimbal_command_unit: top level of the drive and gimbal command unit
// the result is registered after the sequencer steps through MUL1, MUL2, MUL3 and FIN (plus any output stall)
// the unit takes no new request until it is back in IDLE, so the three-multiply duty chain that the
// sequencer steps through handles one request at a time
// reset: synchronous active low; config registers return to defaults, gimbal positions to zero
// depends on tdgc_pkg, tdgc_ctrl, tdgc_dp
module teleop_drive_and_gimbal_command_unit
    import tdgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // turn[7:0], throttle[15:8], gimbal_pan[23:16], gimbal_tilt[31:24], mode_code[39:32]
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // right_forward[0], left_forward[1], right_duty[29:2], left_duty[57:30],
    // pan_positive[58], tilt_positive[59], pan_rate[70:60], tilt_rate[81:71],
    // pan_limit_hit[82], tilt_limit_hit[83], pan_rate_fault[84], tilt_rate_fault[85]
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tdgc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tdgc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (m_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

endmodule

// ===== test/tb_teleop_drive_and_gimbal_command_unit.sv =====
// tb_teleop_drive_and_gimbal_command_unit: self-checking bench for the drive and gimbal unit
// sends hand-picked and random control requests, predicts each command word and compares it
// depends on tdgc_pkg and teleop_drive_and_gimbal_command_unit
module tb_teleop_drive_and_gimbal_command_unit
    import tdgc_pkg::*;
();

    localparam int N_PER_SEGMENT = 175;
    localparam int N_SEGMENTS    = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 10;
    localparam int MAX_REPORTS   = 10;

    // s_axis_tdata layout, lowest field last
    typedef struct packed {
        logic [7:0] mode_code;
        logic [7:0] gimbal_tilt;
        logic [7:0] gimbal_pan;
        logic [7:0] throttle;
        logic [7:0] turn;
    } t_packet;

    // m_axis_tdata[85:0] layout, lowest field last
    typedef struct packed {
        logic        tilt_rate_fault;
        logic        pan_rate_fault;
        logic        tilt_limit_hit;
        logic        pan_limit_hit;
        logic [10:0] tilt_rate;
        logic [10:0] pan_rate;
        logic        tilt_positive;
        logic        pan_positive;
        logic [27:0] left_duty;
        logic [27:0] right_duty;
        logic        left_forward;
        logic        right_forward;
    } t_command;

    typedef enum int {SETUP_RANDOM, SETUP_LOWEST, SETUP_HIGHEST, SETUP_DEFAULTS} t_setup;

    class command_checker;
        int unsigned spin_thr, full_scale, pan_hi, pan_lo, tilt_hi, tilt_lo, pan_max, tilt_max;
        int          pan_pos, tilt_pos;
        t_command    due_commands[$];
        int          failures, requests, results, spins, saturated, limit_hits, rate_faults;

        function new();
            spin_thr   = RST_SPIN_THRESHOLD;
            full_scale = RST_DUTY_FULL_SCALE;
            pan_hi     = RST_PAN_POS_LIMIT;
            pan_lo     = RST_PAN_NEG_LIMIT;
            tilt_hi    = RST_TILT_TOP_LIMIT;
            tilt_lo    = RST_TILT_BOTTOM_LIMIT;
            pan_max    = RST_PAN_MAX_RATE;
            tilt_max   = RST_TILT_MAX_RATE;
            pan_pos    = 0;
            tilt_pos   = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [19:0] val);
            case (idx)
                CFG_SPIN_THRESHOLD:    spin_thr   = val[6:0];
                CFG_DUTY_FULL_SCALE:   full_scale = val;
                CFG_PAN_POS_LIMIT:     pan_hi     = val[15:0];
                CFG_PAN_NEG_LIMIT:     pan_lo     = val[15:0];
                CFG_TILT_TOP_LIMIT:    tilt_hi    = val[15:0];
                CFG_TILT_BOTTOM_LIMIT: tilt_lo    = val[15:0];
                CFG_PAN_MAX_RATE:      pan_max    = val[15:0];
                CFG_TILT_MAX_RATE:     tilt_max   = val[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_commands.size();
        endfunction

        function logic [27:0] duty_of(int mult, int speed);
            longint unsigned m, mag, prod;
            m    = mult;
            mag  = (speed < 0) ? -speed : speed;
            prod = m * full_scale * mag / 127;
            if (prod > DUTY_MAX) begin
                saturated++;
                return DUTY_MAX;
            end
            return prod[27:0];
        endfunction

        // soft limit, accumulate with saturation, then the rate check
        function void step_axis(int cmd, inout int pos, input int unsigned hi, lo, top_rate,
                                output logic [10:0] rate, output logic hit, fault);
            int sum, mag;
            hit   = 0;
            fault = 0;
            if (pos > int'(hi) && cmd > 0) begin
                cmd = 0;
                hit = 1;
            end else if (pos < -int'(lo) && cmd < 0) begin
                cmd = 0;
                hit = 1;
            end
            sum = pos + cmd;
            if (sum > int'(POS_MAX)) sum = int'(POS_MAX);
            if (sum < int'(POS_MIN)) sum = int'(POS_MIN);
            pos = sum;
            mag = (cmd < 0) ? -cmd : cmd;
            if (mag > int'(top_rate)) begin
                mag   = 0;
                fault = 1;
            end
            rate        = mag[10:0];
            limit_hits += hit;
            rate_faults += fault;
        endfunction

        function t_command translate_packet(t_packet p);
            t_command c;
            int turn, throttle, pan_cmd, tilt_cmd, mult, thr, rspd, lspd;
            turn     = $signed(p.turn);
            throttle = $signed(p.throttle);
            pan_cmd  = $signed(p.gimbal_pan);
            tilt_cmd = $signed(p.gimbal_tilt);
            pan_cmd  = pan_cmd * 8;
            tilt_cmd = tilt_cmd * 8;
            mult     = int'(p.mode_code) + 1;
            thr      = spin_thr;
            if (turn > thr) begin
                rspd = -int'(SPIN_SPEED);
                lspd = SPIN_SPEED;
                spins++;
            end else if (turn < -thr) begin
                rspd = SPIN_SPEED;
                lspd = -int'(SPIN_SPEED);
                spins++;
            end else begin
                rspd = throttle;
                lspd = throttle;
            end
            c.right_forward = (rspd >= 0);
            c.left_forward  = (lspd >= 0);
            c.right_duty    = duty_of(mult, rspd);
            c.left_duty     = duty_of(mult, lspd);
            c.pan_positive  = (pan_cmd >= 0);
            c.tilt_positive = (tilt_cmd >= 0);
            step_axis(tilt_cmd, tilt_pos, tilt_hi, tilt_lo, tilt_max,
                      c.tilt_rate, c.tilt_limit_hit, c.tilt_rate_fault);
            step_axis(pan_cmd, pan_pos, pan_hi, pan_lo, pan_max,
                      c.pan_rate, c.pan_limit_hit, c.pan_rate_fault);
            return c;
        endfunction

        function void note_request(t_packet p);
            due_commands.insert(due_commands.size(), translate_packet(p));
            requests++;
        endfunction

        function void compare(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("error: command word %0d field %s expected %0d got %0d",
                             results, name, want, got);
            end
        endfunction

        function void check_result(logic [87:0] data);
            t_command want, got;
            if (due_commands.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("error: command word %h with no request outstanding", data);
                return;
            end
            want = due_commands.pop_front();
            got  = t_command'(data[85:0]);
            compare("right_forward",   want.right_forward,   got.right_forward);
            compare("left_forward",    want.left_forward,    got.left_forward);
            compare("right_duty",      want.right_duty,      got.right_duty);
            compare("left_duty",       want.left_duty,       got.left_duty);
            compare("pan_positive",    want.pan_positive,    got.pan_positive);
            compare("tilt_positive",   want.tilt_positive,   got.tilt_positive);
            compare("pan_rate",        want.pan_rate,        got.pan_rate);
            compare("tilt_rate",       want.tilt_rate,       got.tilt_rate);
            compare("pan_limit_hit",   want.pan_limit_hit,   got.pan_limit_hit);
            compare("tilt_limit_hit",  want.tilt_limit_hit,  got.tilt_limit_hit);
            compare("pan_rate_fault",  want.pan_rate_fault,  got.pan_rate_fault);
            compare("tilt_rate_fault", want.tilt_rate_fault, got.tilt_rate_fault);
            results++;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [19:0] i_cfg_data;

    command_checker sb;
    int src_idle_pct;
    int sink_idle_pct;
    bit hold_req;
    bit pan_up, tilt_up;

    teleop_drive_and_gimbal_command_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // receiver: random stalls, plus one long hold-off on request from the stimulus
    initial begin : sink
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("error: timeout with %0d command words outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_packet make_packet(int turn, int throttle, int pan, int tilt, int mode);
        t_packet p;
        p.turn        = 8'(turn);
        p.throttle    = 8'(throttle);
        p.gimbal_pan  = 8'(pan);
        p.gimbal_tilt = 8'(tilt);
        p.mode_code   = 8'(mode);
        return p;
    endfunction

    // gimbal bytes mostly follow a slowly flipping drift so the accumulators reach the limits
    function automatic logic [7:0] gimbal_byte(bit up);
        if ($urandom_range(99) < 30) return 8'($urandom);
        return up ? 8'($urandom_range(127, 0)) : 8'($urandom_range(255, 128));
    endfunction

    function automatic t_packet random_packet();
        t_packet p;
        int t;
        p.turn        = 8'($urandom);
        p.throttle    = 8'($urandom);
        p.gimbal_pan  = gimbal_byte(pan_up);
        p.gimbal_tilt = gimbal_byte(tilt_up);
        p.mode_code   = 8'($urandom);
        // put turn just around the spin threshold, in either direction, now and then
        if ($urandom_range(99) < 20) begin
            t = int'(sb.spin_thr) + int'($urandom_range(2)) - 1;
            if ($urandom_range(1) == 0) t = -t;
            p.turn = 8'(t);
        end
        case ($urandom_range(9))
            0: p.mode_code = 8'd0;
            1: p.mode_code = 8'd255;
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_packet(t_packet p);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = p;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(p);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic write_all(int unsigned thr, fs, ph, pl, th, tl, pm, tm);
        write_reg(CFG_SPIN_THRESHOLD,    20'(thr));
        write_reg(CFG_DUTY_FULL_SCALE,   20'(fs));
        write_reg(CFG_PAN_POS_LIMIT,     20'(ph));
        write_reg(CFG_PAN_NEG_LIMIT,     20'(pl));
        write_reg(CFG_TILT_TOP_LIMIT,    20'(th));
        write_reg(CFG_TILT_BOTTOM_LIMIT, 20'(tl));
        write_reg(CFG_PAN_MAX_RATE,      20'(pm));
        write_reg(CFG_TILT_MAX_RATE,     20'(tm));
    endtask

    task automatic apply_setup(t_setup s);
        case (s)
            SETUP_LOWEST:   write_all(0, 0, 0, 0, 0, 0, 0, 0);
            SETUP_HIGHEST:  write_all(127, 20'hFFFFF, 16'hFFFF, 16'hFFFF,
                                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            SETUP_DEFAULTS: write_all(RST_SPIN_THRESHOLD, RST_DUTY_FULL_SCALE,
                                      RST_PAN_POS_LIMIT, RST_PAN_NEG_LIMIT,
                                      RST_TILT_TOP_LIMIT, RST_TILT_BOTTOM_LIMIT,
                                      RST_PAN_MAX_RATE, RST_TILT_MAX_RATE);
            default:        write_all($urandom_range(127), $urandom_range(1000000),
                                      $urandom_range(6000, 200), $urandom_range(6000, 200),
                                      $urandom_range(6000, 200), $urandom_range(6000, 200),
                                      $urandom_range(1100, 300), $urandom_range(1100, 300));
        endcase
    endtask

    // block idle: nothing outstanding and the pipeline given time to settle
    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_packet early[$];
        t_packet late[$];
        t_setup  s;
        int      seg, k;
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_SPIN_THRESHOLD;
        i_cfg_data    = '0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_req      = 1'b0;
        pan_up        = 1'b1;
        tilt_up       = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: spin both ways, threshold edges, stick and mode extremes
        early = '{make_packet(0, 0, 0, 0, 0),
                  make_packet(81, 127, 127, 127, 255),
                  make_packet(-81, -128, -128, -128, 255),
                  make_packet(80, 127, 0, 0, 0),
                  make_packet(-80, -128, 0, 0, 255),
                  make_packet(127, 0, 1, -1, 7),
                  make_packet(-128, 0, -1, 1, 128),
                  make_packet(0, 127, 127, 127, 255),
                  make_packet(0, -128, -128, -128, 255),
                  make_packet(0, -1, 0, 0, 0),
                  make_packet(0, 1, 127, -128, 1),
                  make_packet(85, -86, 85, -86, 170),
                  make_packet(-86, 85, -86, 85, 85)};
        // zero limits and low rate ceilings: limit stops and rate faults straight away
        late  = '{make_packet(1, 0, 127, 127, 0),
                  make_packet(0, 5, 127, 127, 3),
                  make_packet(-1, 5, -128, -128, 3),
                  make_packet(0, -7, -128, -128, 9),
                  make_packet(0, -128, -128, 127, 255),
                  make_packet(0, 127, 127, -128, 255)};
        foreach (early[i]) send_packet(early[i]);
        drain();
        write_all(0, 1000000, 0, 0, 0, 0, 1016, 512);
        foreach (late[i]) send_packet(late[i]);
        drain();

        for (seg = 0; seg < N_SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin src_idle_pct = 19; sink_idle_pct = 49; end
                1: begin src_idle_pct = 49; sink_idle_pct = 19; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            case (seg)
                1:       s = SETUP_LOWEST;
                3:       s = SETUP_HIGHEST;
                5:       s = SETUP_DEFAULTS;
                default: s = SETUP_RANDOM;
            endcase
            apply_setup(s);
            // long output stall while requests keep coming, so the unit backs up
            if (seg == 4) hold_req = 1'b1;
            for (k = 0; k < N_PER_SEGMENT; k++) begin
                if ($urandom_range(49) == 0) pan_up = !pan_up;
                if ($urandom_range(49) == 0) tilt_up = !tilt_up;
                send_packet(random_packet());
            end
            drain();
        end

        if (sb.pending() != 0)
            $display("error: %0d command words never arrived", sb.pending());
        $display("covered %0d requests and %0d command words over %0d register settings",
                 sb.requests, sb.results, N_SEGMENTS + 2);
        $display("spins %0d, soft-limit stops %0d, rate faults %0d, saturated duties %0d",
                 sb.spins, sb.limit_hits, sb.rate_faults, sb.saturated);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.failures);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tdgc_pkg.sv
rtl/core/tdgc_ctrl.sv
rtl/core/tdgc_dp.sv
rtl/core/teleop_drive_and_gimbal_command_unit.sv
test/tb_teleop_drive_and_gimbal_command_unit.sv
